// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication with the same reset handling.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== sv/btgc_pkg.sv =====
`timescale 1ns / 1ps

package btgc_pkg;

	// Wide enough for any box edge and any tile edge of a 64 x 64 grid of 64-pixel tiles.
	localparam int COORD_W = 14;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic signed [3:0] CODE_SOLID_A = 4'sd1;
	localparam logic signed [3:0] CODE_SOLID_B = 4'sd2;

	// Box edges a and b against tile span s..e on one axis.
	function automatic logic axis_hit(coord_t a, coord_t b, coord_t s, coord_t e);
		return ((a > s) && (a < e)) || ((b > s) && (b < e)) ||
			((a < s) && (b > e)) || (a == s) || (b == e);
	endfunction

	function automatic coord_t sext12(logic signed [11:0] v);
		return coord_t'(v);
	endfunction

endpackage

// ===== sv/btgc_ram.sv =====
`timescale 1ns / 1ps

module btgc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/btgc_col_mask.sv =====
`timescale 1ns / 1ps

// Registers, for one query, which columns overlap the box on the x axis.
module btgc_col_mask #(
	parameter int GRID_COLS   = 32,
	parameter int TILE_PIXELS = 32
) (
	input  logic                 clk,
	input  logic                 capture,
	input  logic signed [11:0]   box_x_start,
	input  logic signed [11:0]   box_x_end,
	output logic [GRID_COLS-1:0] mask_q
);

	btgc_pkg::coord_t xs;
	btgc_pkg::coord_t xe;
	logic [GRID_COLS-1:0] mask_d;

	assign xs = btgc_pkg::sext12(box_x_start);
	assign xe = btgc_pkg::sext12(box_x_end);

	for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
		localparam btgc_pkg::coord_t SPAN_S = btgc_pkg::coord_t'(c * TILE_PIXELS);
		localparam btgc_pkg::coord_t SPAN_E = btgc_pkg::coord_t'((c + 1) * TILE_PIXELS);
		assign mask_d[c] = btgc_pkg::axis_hit(xs, xe, SPAN_S, SPAN_E);
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			mask_q <= mask_d;
		end
	end

endmodule

// ===== sv/box_tile_grid_collision_core.sv =====
`timescale 1ns / 1ps

// Solid-tile grid with box collision queries. One item is worked on at a time.
// A load item reads the row word from the row memory and writes it back with
// the one tile bit changed; loads outside the grid change nothing. A query
// item runs a scan that reads one row word per cycle from the row memory and
// tests every column of that row at once against the box; the x test is done
// once per query into a column mask. A query's hit result sits in an output
// register, so the next item is taken while it waits; a query that finishes
// while the previous result is still not taken holds until the register frees.
// After reset the grid reads as all clear at once: a per-row valid bit stands
// for each row not yet written, so no clearing pass is needed.
module box_tile_grid_collision_core #(
	parameter int GRID_ROWS   = 32,
	parameter int GRID_COLS   = 32,
	parameter int TILE_PIXELS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic              op,
	input  logic [4:0]        tile_row,
	input  logic [4:0]        tile_col,
	input  logic signed [3:0] tile_code,
	input  logic signed [11:0] box_x_start,
	input  logic signed [11:0] box_x_end,
	input  logic signed [11:0] box_y_start,
	input  logic signed [11:0] box_y_end,
	output logic              result_valid,
	input  logic              result_ready,
	output logic              hit
);

	localparam int RAW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int CW  = btgc_pkg::COORD_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_FLUSH = 3'd3;
	localparam logic [2:0] ST_PUT   = 3'd4;

	logic [2:0]           state_q;
	logic                 accept;
	logic                 slot_free;

	logic [RAW-1:0]       row_q;
	logic [GRID_COLS-1:0] col_hot_q;
	logic                 solid_q;
	logic                 in_range_q;
	logic [GRID_COLS-1:0] col_hot_d;

	logic [GRID_ROWS-1:0] row_vld_q;
	logic                 we;
	logic [RAW-1:0]       raddr;
	logic [GRID_COLS-1:0] rdata;
	logic [GRID_COLS-1:0] old_word;
	logic [GRID_COLS-1:0] wdata;

	logic [RAW-1:0]       scan_q;
	logic [RAW-1:0]       row_s1;
	logic                 vld_s1;
	btgc_pkg::coord_t     ys_q;
	btgc_pkg::coord_t     ye_q;
	btgc_pkg::coord_t     span_s;
	btgc_pkg::coord_t     span_e;
	logic [GRID_COLS-1:0] xmask;
	logic [GRID_COLS-1:0] scan_word;
	logic                 row_hit;
	logic                 acc_q;

	logic                 result_valid_q;
	logic                 hit_q;

	assign item_ready   = (state_q == ST_IDLE);
	assign accept       = item_valid && item_ready;
	assign result_valid = result_valid_q;
	assign hit          = hit_q;
	assign slot_free    = !result_valid_q || result_ready;

	always_comb begin
		for (int c = 0; c < GRID_COLS; c++) begin
			col_hot_d[c] = (7'(tile_col) == 7'(c));
		end
	end

	// During idle the memory is read at the loaded row, otherwise at the scan row.
	assign raddr    = (state_q == ST_IDLE) ? RAW'(tile_row) : scan_q;
	assign old_word = row_vld_q[row_q] ? rdata : '0;
	assign wdata    = (old_word & ~col_hot_q) | (solid_q ? col_hot_q : '0);
	assign we       = (state_q == ST_LOAD) && in_range_q;

	btgc_ram #(
		.WIDTH(GRID_COLS),
		.DEPTH(GRID_ROWS)
	) u_rows (
		.clk  (clk),
		.we   (we),
		.waddr(row_q),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	btgc_col_mask #(
		.GRID_COLS  (GRID_COLS),
		.TILE_PIXELS(TILE_PIXELS)
	) u_col_mask (
		.clk        (clk),
		.capture    (accept),
		.box_x_start(box_x_start),
		.box_x_end  (box_x_end),
		.mask_q     (xmask)
	);

	assign span_s    = btgc_pkg::coord_t'(CW'(row_s1) * CW'(TILE_PIXELS));
	assign span_e    = span_s + btgc_pkg::coord_t'(TILE_PIXELS);
	assign scan_word = row_vld_q[row_s1] ? rdata : '0;
	assign row_hit   = vld_s1 && (|(scan_word & xmask)) &&
		btgc_pkg::axis_hit(ys_q, ye_q, span_s, span_e);

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q      <= RAW'(tile_row);
			col_hot_q  <= col_hot_d;
			solid_q    <= (tile_code == btgc_pkg::CODE_SOLID_A) ||
				(tile_code == btgc_pkg::CODE_SOLID_B);
			in_range_q <= (7'(tile_row) < 7'(GRID_ROWS)) && (7'(tile_col) < 7'(GRID_COLS));
			ys_q       <= btgc_pkg::sext12(box_y_start);
			ye_q       <= btgc_pkg::sext12(box_y_end);
		end
		row_s1 <= scan_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			row_vld_q      <= '0;
			scan_q         <= '0;
			vld_s1         <= 1'b0;
			acc_q          <= 1'b0;
			result_valid_q <= 1'b0;
			hit_q          <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN);
			if ((state_q == ST_PUT) && slot_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (we) begin
				row_vld_q[row_q] <= 1'b1;
			end
			if (row_hit) begin
				acc_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						scan_q <= '0;
						acc_q  <= 1'b0;
						state_q <= (op == btgc_pkg::OP_QUERY) ? ST_SCAN : ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == RAW'(GRID_ROWS - 1)) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_PUT;
				end
				ST_PUT: begin
					if (slot_free) begin
						hit_q   <= acc_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/btgc_chk.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module btgc_chk (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input logic op,
	input logic result_valid,
	input logic result_ready,
	input logic hit
);

	`ASSERT_IMPL(a_result_holds, clk, arst_n, $past(result_valid && !result_ready), result_valid && $stable(hit), "result item changed or dropped while stalled")

	`ASSERT_IMPL(a_load_no_result, clk, arst_n, $past(item_valid && item_ready && !op && !result_valid), !result_valid, "load item produced a result")

	`ASSERT_IMPL(a_query_busy, clk, arst_n, $past(item_valid && item_ready && op), !item_ready, "block took a new item right after a query")

	`ASSERT_IMPL(a_result_after_busy, clk, arst_n, $rose(result_valid), !$past(item_ready), "result appeared without a query at work")

endmodule

bind box_tile_grid_collision_core btgc_chk u_btgc_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_ready  (item_ready),
	.op          (op),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.hit         (hit)
);
